// ----- hw/rtl/assert_macros.svh -----
// assertion macros for the matcher rtl
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ACM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);
`define ACM_ASSERT_ALW(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
    else $error(msg);
`else
`define ACM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define ACM_ASSERT_ALW(lbl, clk, rstn, cond, msg)
`endif
`endif

// ----- hw/rtl/acm_pkg.sv -----
// types, codes and defaults for the aho-corasick list matcher
// no dependencies
package acm_pkg;

  localparam int LINK_W = 10;
  localparam int SYM_W  = 8;
  localparam int ID_W   = 16;

  localparam int DEF_STATE_COUNT = 1024;
  localparam int DEF_EDGE_COUNT  = 1024;
  localparam int DEF_ID_BITS     = 16;

  typedef enum logic [1:0] {
    OP_SCAN     = 2'd0,
    OP_WR_NODE  = 2'd1,
    OP_WR_EDGE  = 2'd2,
    OP_ROOT     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NODE,
    ST_EDGE,
    ST_OUT1,
    ST_OUT2
  } walk_state_t;

  typedef struct packed {
    logic [LINK_W-1:0] first_edge;
    logic              first_valid;
    logic [LINK_W-1:0] fail;
    logic [LINK_W-1:0] out_link;
    logic [ID_W-1:0]   id;
  } node_entry_t;

  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic [LINK_W-1:0] target;
    logic [LINK_W-1:0] next;
    logic              next_valid;
  } edge_entry_t;

  typedef struct packed {
    logic              en;
    logic [LINK_W-1:0] addr;
    node_entry_t       data;
  } node_wr_t;

  typedef struct packed {
    logic              en;
    logic [LINK_W-1:0] addr;
    edge_entry_t       data;
  } edge_wr_t;

  typedef struct packed {
    logic              en;
    logic [LINK_W-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    op_t               opcode;
    logic [LINK_W-1:0] entry_index;
    logic [SYM_W-1:0]  symbol;
    logic [LINK_W-1:0] link_edge;
    logic              link_edge_valid;
    logic [LINK_W-1:0] state_link_a;
    logic [LINK_W-1:0] state_link_b;
    logic [ID_W-1:0]   pattern_value;
  } in_item_t;

endpackage

// ----- hw/rtl/acm_node_mem.sv -----
// state table memory, one write and one registered read port
// depends on acm_pkg
module acm_node_mem import acm_pkg::*; #(
  parameter int DEPTH = DEF_STATE_COUNT
) (
  input  logic        clk,
  input  node_wr_t    wr,
  input  mem_rd_t     rd,
  output node_entry_t rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  node_entry_t mem [DEPTH];
  node_entry_t rd_q_r;
  logic        rd_ok_r;
  logic [31:0] wr_ext;
  logic [31:0] rd_ext;

  assign wr_ext = 32'(wr.addr);
  assign rd_ext = 32'(rd.addr);

  always_ff @(posedge clk) begin
    if (wr.en && (wr_ext < 32'(DEPTH))) begin
      mem[wr_ext[AW-1:0]] <= wr.data;
    end
  end

  // links beyond the table read as an all-zero entry
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_ok_r <= rd_ext < 32'(DEPTH);
      rd_q_r  <= mem[rd_ext[AW-1:0]];
    end
  end

  assign rd_data = rd_ok_r ? rd_q_r : '0;

endmodule

// ----- hw/rtl/acm_edge_mem.sv -----
// edge table memory, one write and one registered read port
// depends on acm_pkg
module acm_edge_mem import acm_pkg::*; #(
  parameter int DEPTH = DEF_EDGE_COUNT
) (
  input  logic        clk,
  input  edge_wr_t    wr,
  input  mem_rd_t     rd,
  output edge_entry_t rd_data,
  output logic        rd_ok
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  edge_entry_t mem [DEPTH];
  edge_entry_t rd_q_r;
  logic        rd_ok_r;
  logic [31:0] wr_ext;
  logic [31:0] rd_ext;

  assign wr_ext = 32'(wr.addr);
  assign rd_ext = 32'(rd.addr);

  always_ff @(posedge clk) begin
    if (wr.en && (wr_ext < 32'(DEPTH))) begin
      mem[wr_ext[AW-1:0]] <= wr.data;
    end
  end

  // an edge link beyond the table ends the list
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_ok_r <= rd_ext < 32'(DEPTH);
      rd_q_r  <= mem[rd_ext[AW-1:0]];
    end
  end

  assign rd_data = rd_q_r;
  assign rd_ok   = rd_ok_r;

endmodule

// ----- hw/rtl/acm_walk_ctrl.sv -----
// walk sequencer: child list walk, failure hops, output link lookup
// depends on acm_pkg and assert_macros.svh
`include "assert_macros.svh"
module acm_walk_ctrl import acm_pkg::*; #(
  parameter int STATE_COUNT = DEF_STATE_COUNT,
  parameter int EDGE_COUNT  = DEF_EDGE_COUNT,
  parameter int ID_BITS     = DEF_ID_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  in_item_t          item,
  input  logic [ID_W-1:0]   null_value,
  output logic              busy,
  output node_wr_t          node_wr,
  output mem_rd_t           node_rd,
  input  node_entry_t       node_q,
  output edge_wr_t          edge_wr,
  output mem_rd_t           edge_rd,
  input  edge_entry_t       edge_q,
  input  logic              edge_ok,
  output logic              out_valid,
  output logic [ID_W-1:0]   out_id,
  output logic              out_found,
  output logic [LINK_W-1:0] out_state
);

  localparam int HW = $clog2(STATE_COUNT + 1);
  localparam int SW = (EDGE_COUNT > 1) ? $clog2(EDGE_COUNT + 1) : 1;
  localparam logic [ID_W-1:0] ID_MASK =
    (ID_BITS >= ID_W) ? {ID_W{1'b1}} : ID_W'((33'd1 << ID_BITS) - 33'd1);

  walk_state_t       state_r, state_nxt;
  logic [LINK_W-1:0] cur_r, cur_nxt;
  logic [LINK_W-1:0] s_r, s_nxt;
  logic [LINK_W-1:0] fail_r, fail_nxt;
  logic [HW-1:0]     hops_r, hops_nxt;
  logic [SW-1:0]     steps_r, steps_nxt;
  logic [SYM_W-1:0]  sym_r, sym_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;
  logic              out_found_r, out_found_nxt;
  logic [LINK_W-1:0] out_state_r, out_state_nxt;

  logic [LINK_W-1:0] fail_w;
  logic              can_hop;
  logic              node_miss;
  logic              edge_hit;
  logic              edge_more;
  logic [SW-1:0]     steps_inc;
  logic [ID_W-1:0]   id_masked;

  // shared decisions
  always_comb begin
    fail_w    = (state_r == ST_NODE) ? node_q.fail : fail_r;
    can_hop   = (s_r != '0) && (32'(hops_r) < 32'(STATE_COUNT));
    node_miss = !node_q.first_valid;
    steps_inc = steps_r + SW'(1);
    edge_hit  = edge_ok && (edge_q.sym == sym_r);
    edge_more = edge_ok && edge_q.next_valid && (32'(steps_inc) < 32'(EDGE_COUNT));
    id_masked = node_q.id & ID_MASK;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start && (item.opcode == OP_SCAN)) begin
          state_nxt = ST_NODE;
        end
      end
      ST_NODE: begin
        if (!node_miss) begin
          state_nxt = ST_EDGE;
        end else begin
          state_nxt = can_hop ? ST_NODE : ST_OUT1;
        end
      end
      ST_EDGE: begin
        if (edge_hit) begin
          state_nxt = ST_OUT1;
        end else if (edge_more) begin
          state_nxt = ST_EDGE;
        end else begin
          state_nxt = can_hop ? ST_NODE : ST_OUT1;
        end
      end
      ST_OUT1: state_nxt = ST_OUT2;
      ST_OUT2: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    node_wr       = '0;
    edge_wr       = '0;
    node_rd.en    = 1'b0;
    node_rd.addr  = s_r;
    edge_rd.en    = 1'b0;
    edge_rd.addr  = edge_q.next;
    cur_nxt       = cur_r;
    s_nxt         = s_r;
    fail_nxt      = fail_r;
    hops_nxt      = hops_r;
    steps_nxt     = steps_r;
    sym_nxt       = sym_r;
    out_valid_nxt = 1'b0;
    out_id_nxt    = out_id_r;
    out_found_nxt = out_found_r;
    out_state_nxt = out_state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (item.opcode)
            OP_SCAN: begin
              node_rd.en   = 1'b1;
              node_rd.addr = cur_r;
              s_nxt        = cur_r;
              hops_nxt     = '0;
              sym_nxt      = item.symbol;
            end
            OP_WR_NODE: begin
              node_wr.en               = 1'b1;
              node_wr.addr             = item.entry_index;
              node_wr.data.first_edge  = item.link_edge;
              node_wr.data.first_valid = item.link_edge_valid;
              node_wr.data.fail        = item.state_link_a;
              node_wr.data.out_link    = item.state_link_b;
              node_wr.data.id          = item.pattern_value;
            end
            OP_WR_EDGE: begin
              edge_wr.en              = 1'b1;
              edge_wr.addr            = item.entry_index;
              edge_wr.data.sym        = item.symbol;
              edge_wr.data.target     = item.state_link_a;
              edge_wr.data.next       = item.link_edge;
              edge_wr.data.next_valid = item.link_edge_valid;
            end
            OP_ROOT: cur_nxt = '0;
            default: cur_nxt = cur_r;
          endcase
        end
      end
      ST_NODE, ST_EDGE: begin
        if (state_r == ST_NODE) begin
          fail_nxt = node_q.fail;
        end
        if ((state_r == ST_NODE) && !node_miss) begin
          edge_rd.en   = 1'b1;
          edge_rd.addr = node_q.first_edge;
          steps_nxt    = '0;
        end else if ((state_r == ST_EDGE) && edge_hit) begin
          node_rd.en   = 1'b1;
          node_rd.addr = edge_q.target;
          s_nxt        = edge_q.target;
        end else if ((state_r == ST_EDGE) && edge_more) begin
          edge_rd.en   = 1'b1;
          edge_rd.addr = edge_q.next;
          steps_nxt    = steps_inc;
        end else if (can_hop) begin
          node_rd.en   = 1'b1;
          node_rd.addr = fail_w;
          s_nxt        = fail_w;
          hops_nxt     = hops_r + HW'(1);
        end else begin
          // miss at the root or chain exhausted: land on the root
          node_rd.en   = 1'b1;
          node_rd.addr = '0;
          s_nxt        = '0;
        end
      end
      ST_OUT1: begin
        node_rd.en   = 1'b1;
        node_rd.addr = node_q.out_link;
      end
      ST_OUT2: begin
        out_valid_nxt = 1'b1;
        out_id_nxt    = id_masked;
        out_found_nxt = id_masked != (null_value & ID_MASK);
        out_state_nxt = s_r;
        cur_nxt       = s_r;
      end
      default: cur_nxt = cur_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r         <= s_nxt;
    fail_r      <= fail_nxt;
    hops_r      <= hops_nxt;
    steps_r     <= steps_nxt;
    sym_r       <= sym_nxt;
    out_id_r    <= out_id_nxt;
    out_found_r <= out_found_nxt;
    out_state_r <= out_state_nxt;
  end

  assign busy      = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_id    = out_id_r;
  assign out_found = out_found_r;
  assign out_state = out_state_r;

  `ACM_ASSERT_IMP(a_strobe_after_lookup, clk, rst_n, out_valid_r, $past(state_r == ST_OUT2), "result strobe without output lookup")
  `ACM_ASSERT_IMP(a_write_only_idle, clk, rst_n, node_wr.en || edge_wr.en, state_r == ST_IDLE, "table write during a walk")
  `ACM_ASSERT_IMP(a_state_follows, clk, rst_n, out_valid_r, cur_r == out_state_r, "current node differs from reported state")
  `ACM_ASSERT_IMP(a_hops_bound, clk, rst_n, state_r == ST_NODE, 32'(hops_r) <= 32'(STATE_COUNT), "failure hop count beyond bound")

endmodule

// ----- hw/rtl/aho_corasick_list_matcher_unit.sv -----
// top level of the aho-corasick list matcher: config register, tables, walk sequencer
// depends on acm_pkg, acm_node_mem, acm_edge_mem, acm_walk_ctrl
//
//  channel   handshake               payload
//  input     start / busy            in_opcode .. in_pattern_value
//  result    out_valid (1 cycle)     out_match_id, out_match_found, out_new_state
//  config    cfg_wr_en               cfg_wr_data (null pattern id)
//
// write and return-to-root items are taken while idle; busy stays low
// a scan item holds busy high while it reads each visited state and each edge examined, then the output link entry,
//   set by the one read port of each table memory; the result strobe comes in the cycle after the last busy one
// a miss visits the current state and each state along its failure chain
// synchronous active-low reset clears the sequencer, the current node and the null id;
//   table contents are undefined until written
// results cannot be held off; the next item may start in the strobe cycle
module aho_corasick_list_matcher_unit import acm_pkg::*; #(
  parameter int STATE_COUNT = DEF_STATE_COUNT,
  parameter int EDGE_COUNT  = DEF_EDGE_COUNT,
  parameter int ID_BITS     = DEF_ID_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  // item in
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_opcode,
  input  logic [LINK_W-1:0] in_entry_index,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic [LINK_W-1:0] in_link_edge,
  input  logic              in_link_edge_valid,
  input  logic [LINK_W-1:0] in_state_link_a,
  input  logic [LINK_W-1:0] in_state_link_b,
  input  logic [ID_W-1:0]   in_pattern_value,
  // result out
  output logic              out_valid,
  output logic [ID_W-1:0]   out_match_id,
  output logic              out_match_found,
  output logic [LINK_W-1:0] out_new_state,
  // configuration
  input  logic              cfg_wr_en,
  input  logic [ID_W-1:0]   cfg_wr_data
);

  logic [ID_W-1:0] null_r, null_nxt;
  in_item_t        item;
  node_wr_t        node_wr;
  mem_rd_t         node_rd;
  node_entry_t     node_q;
  edge_wr_t        edge_wr;
  mem_rd_t         edge_rd;
  edge_entry_t     edge_q;
  logic            edge_ok;

  // null pattern id register
  always_comb begin
    null_nxt = cfg_wr_en ? cfg_wr_data : null_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      null_r <= '0;
    end else begin
      null_r <= null_nxt;
    end
  end

  // bundle the item fields
  always_comb begin
    item.opcode          = op_t'(in_opcode);
    item.entry_index     = in_entry_index;
    item.symbol          = in_symbol;
    item.link_edge       = in_link_edge;
    item.link_edge_valid = in_link_edge_valid;
    item.state_link_a    = in_state_link_a;
    item.state_link_b    = in_state_link_b;
    item.pattern_value   = in_pattern_value;
  end

  // state table: first edge, failure link, output link, pattern id
  acm_node_mem #(
    .DEPTH (STATE_COUNT)
  ) u_node_mem (
    .clk     (clk),
    .wr      (node_wr),
    .rd      (node_rd),
    .rd_data (node_q)
  );

  // edge table: character, target, next sibling
  acm_edge_mem #(
    .DEPTH (EDGE_COUNT)
  ) u_edge_mem (
    .clk     (clk),
    .wr      (edge_wr),
    .rd      (edge_rd),
    .rd_data (edge_q),
    .rd_ok   (edge_ok)
  );

  // sequencer issues one read per table per cycle; writes happen only while idle,
  // so a read never overlaps a write to the same entry
  acm_walk_ctrl #(
    .STATE_COUNT (STATE_COUNT),
    .EDGE_COUNT  (EDGE_COUNT),
    .ID_BITS     (ID_BITS)
  ) u_walk_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .item       (item),
    .null_value (null_r),
    .busy       (busy),
    .node_wr    (node_wr),
    .node_rd    (node_rd),
    .node_q     (node_q),
    .edge_wr    (edge_wr),
    .edge_rd    (edge_rd),
    .edge_q     (edge_q),
    .edge_ok    (edge_ok),
    .out_valid  (out_valid),
    .out_id     (out_match_id),
    .out_found  (out_match_found),
    .out_state  (out_new_state)
  );

endmodule

// ----- verif/tb_aho_corasick_list_matcher_unit.sv -----
// testbench for aho_corasick_list_matcher_unit: loads small automata into the state and
// edge tables, scans bytes and checks every match result against an in-bench predictor
// depends on acm_pkg and the matcher rtl only
module tb_aho_corasick_list_matcher_unit;
  import acm_pkg::*;

  localparam int STATE_COUNT     = DEF_STATE_COUNT;
  localparam int EDGE_COUNT      = DEF_EDGE_COUNT;
  localparam int ITEM_TARGET     = 1600;      // random phases stop once past this
  localparam int SCAN_CYCLE_CAP  = 400;       // keeps random scans away from very long walks
  localparam int IDLE_SETTLE     = 4;         // settle time for write items after the last result
  localparam int TIMEOUT_TICKS   = 8_000_000; // hang guard limit in simulation time units

  // byte values and table slots of the hand-built automaton
  localparam logic [SYM_W-1:0]  SYM_LO     = 8'h00;
  localparam logic [SYM_W-1:0]  SYM_HI     = 8'hFF;
  localparam logic [SYM_W-1:0]  SYM_BACK   = 8'h5A;
  localparam logic [SYM_W-1:0]  SYM_STRAY  = 8'h37;
  localparam logic [LINK_W-1:0] ROOT       = 10'd0;
  localparam logic [LINK_W-1:0] NODE_LO    = 10'd1023;
  localparam logic [LINK_W-1:0] NODE_LOHI  = 10'd1;
  localparam logic [LINK_W-1:0] NODE_HI    = 10'd2;
  localparam logic [LINK_W-1:0] EDGE_R_LO  = 10'd1023;
  localparam logic [LINK_W-1:0] EDGE_R_HI  = 10'd5;
  localparam logic [LINK_W-1:0] EDGE_LO_HI = 10'd0;
  localparam logic [LINK_W-1:0] EDGE_BACK  = 10'd7;

  typedef struct packed {
    logic [ID_W-1:0]   match_id;
    logic              match_found;
    logic [LINK_W-1:0] new_state;
  } match_result_t;

  // dut connections, every input known from time zero
  logic              clk;
  logic              rst_n              = 1'b0;
  logic              start              = 1'b0;
  logic              busy;
  logic [1:0]        in_opcode          = '0;
  logic [LINK_W-1:0] in_entry_index     = '0;
  logic [SYM_W-1:0]  in_symbol          = '0;
  logic [LINK_W-1:0] in_link_edge       = '0;
  logic              in_link_edge_valid = 1'b0;
  logic [LINK_W-1:0] in_state_link_a    = '0;
  logic [LINK_W-1:0] in_state_link_b    = '0;
  logic [ID_W-1:0]   in_pattern_value   = '0;
  logic              out_valid;
  logic [ID_W-1:0]   out_match_id;
  logic              out_match_found;
  logic [LINK_W-1:0] out_new_state;
  logic              cfg_wr_en          = 1'b0;
  logic [ID_W-1:0]   cfg_wr_data        = '0;

  // shadow of the matcher: tables, which entries hold data, current node, null id
  node_entry_t       node_shadow [STATE_COUNT] = '{default: '0};
  edge_entry_t       edge_shadow [EDGE_COUNT]  = '{default: '0};
  bit                node_written[STATE_COUNT];
  bit                edge_written[EDGE_COUNT];
  logic [LINK_W-1:0] cur_node = '0;
  logic [ID_W-1:0]   null_id  = '0;

  match_result_t     pending_matches[$];
  int                error_count = 0;
  int                items_sent  = 0;
  int                burst_left  = 0;

  // automaton of the current random phase
  logic [LINK_W-1:0] trie_nodes[$];
  logic [LINK_W-1:0] trie_edges[$];
  logic [SYM_W-1:0]  alphabet[4];

  aho_corasick_list_matcher_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_entry_index     (in_entry_index),
    .in_symbol          (in_symbol),
    .in_link_edge       (in_link_edge),
    .in_link_edge_valid (in_link_edge_valid),
    .in_state_link_a    (in_state_link_a),
    .in_state_link_b    (in_state_link_b),
    .in_pattern_value   (in_pattern_value),
    .out_valid          (out_valid),
    .out_match_id       (out_match_id),
    .out_match_found    (out_match_found),
    .out_new_state      (out_new_state),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // walk one child list; the cycle tally grows with each state visit and each edge read
  function automatic bit child_search(input logic [LINK_W-1:0] node, input logic [SYM_W-1:0] sym,
      output logic [LINK_W-1:0] target, inout int cycles, inout bit unsafe);
    node_entry_t       n;
    logic [LINK_W-1:0] e;
    target = '0;
    if (!node_written[node]) unsafe = 1'b1;
    n = node_shadow[node];
    cycles += 1;
    if (!n.first_valid) return 1'b0;
    e = n.first_edge;
    // a cyclic list gives up after one pass worth of edges and counts as a miss
    for (int steps = 0; steps < EDGE_COUNT; steps++) begin
      if (!edge_written[e]) unsafe = 1'b1;
      cycles += 1;
      if (edge_shadow[e].sym == sym) begin
        target = edge_shadow[e].target;
        return 1'b1;
      end
      if (!edge_shadow[e].next_valid) return 1'b0;
      e = edge_shadow[e].next;
    end
    return 1'b0;
  endfunction

  // result of scanning one byte from cur_node; flags walks that touch unwritten entries
  function automatic void predict_scan(input logic [SYM_W-1:0] sym, output match_result_t res,
      output int cycles, output bit unsafe);
    logic [LINK_W-1:0] s;
    logic [LINK_W-1:0] tgt;
    logic [LINK_W-1:0] ns;
    logic [LINK_W-1:0] out_node;
    int                hops;
    bit                hit;
    cycles = 3;
    unsafe = 1'b0;
    s      = cur_node;
    hit    = child_search(s, sym, tgt, cycles, unsafe);
    hops   = 0;
    // on a miss climb the failure chain until a child matches or the root is reached
    while (!hit && s != ROOT && hops < STATE_COUNT) begin
      s   = node_shadow[s].fail;
      hit = child_search(s, sym, tgt, cycles, unsafe);
      hops++;
    end
    // a failure chain that never reaches the root is cut off at the root
    if (!hit && s != ROOT) s = ROOT;
    ns = hit ? tgt : s;
    if (!node_written[ns]) unsafe = 1'b1;
    out_node = node_shadow[ns].out_link;
    if (!node_written[out_node]) unsafe = 1'b1;
    res.match_id    = node_shadow[out_node].id;
    res.match_found = (node_shadow[out_node].id != null_id);
    res.new_state   = ns;
  endfunction

  // update the shadow for an item the dut just took
  function automatic void apply_item(input in_item_t item);
    match_result_t res;
    int            cycles;
    bit            unsafe;
    case (item.opcode)
      OP_WR_NODE: begin
        node_shadow[item.entry_index] = '{first_edge: item.link_edge,
                                          first_valid: item.link_edge_valid,
                                          fail: item.state_link_a,
                                          out_link: item.state_link_b,
                                          id: item.pattern_value};
        node_written[item.entry_index] = 1'b1;
      end
      OP_WR_EDGE: begin
        edge_shadow[item.entry_index] = '{sym: item.symbol,
                                          target: item.state_link_a,
                                          next: item.link_edge,
                                          next_valid: item.link_edge_valid};
        edge_written[item.entry_index] = 1'b1;
      end
      OP_ROOT: begin
        cur_node = ROOT;
      end
      default: begin
        predict_scan(item.symbol, res, cycles, unsafe);
        pending_matches.push_back(res);
        cur_node = res.new_state;
      end
    endcase
  endfunction

  // every field random, so fields an opcode ignores still toggle
  function automatic in_item_t random_item();
    logic [95:0] raw;
    raw = {$urandom(), $urandom(), $urandom()};
    return in_item_t'(raw[$bits(in_item_t)-1:0]);
  endfunction

  function automatic bit in_list(input logic [LINK_W-1:0] q[$], input logic [LINK_W-1:0] v);
    foreach (q[k]) if (q[k] == v) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [LINK_W-1:0] pick_node();
    return trie_nodes[$urandom_range(0, trie_nodes.size() - 1)];
  endfunction

  function automatic logic [LINK_W-1:0] pick_edge();
    return trie_edges[$urandom_range(0, trie_edges.size() - 1)];
  endfunction

  // present one item; bursts of random length with random gaps, some bursts back to back
  task automatic send_item(input in_item_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start              <= 1'b1;
    in_opcode          <= item.opcode;
    in_entry_index     <= item.entry_index;
    in_symbol          <= item.symbol;
    in_link_edge       <= item.link_edge;
    in_link_edge_valid <= item.link_edge_valid;
    in_state_link_a    <= item.state_link_a;
    in_state_link_b    <= item.state_link_b;
    in_pattern_value   <= item.pattern_value;
    // taken at the first edge that sees busy low
    do @(posedge clk); while (busy !== 1'b0);
    apply_item(item);
    items_sent++;
  endtask

  task automatic write_node(input logic [LINK_W-1:0] idx, input logic [LINK_W-1:0] first,
      input logic first_ok, input logic [LINK_W-1:0] fail, input logic [LINK_W-1:0] out_link,
      input logic [ID_W-1:0] id);
    in_item_t item;
    item                 = random_item();
    item.opcode          = OP_WR_NODE;
    item.entry_index     = idx;
    item.link_edge       = first;
    item.link_edge_valid = first_ok;
    item.state_link_a    = fail;
    item.state_link_b    = out_link;
    item.pattern_value   = id;
    send_item(item);
  endtask

  task automatic write_edge(input logic [LINK_W-1:0] idx, input logic [SYM_W-1:0] sym,
      input logic [LINK_W-1:0] target, input logic [LINK_W-1:0] next, input logic next_ok);
    in_item_t item;
    item                 = random_item();
    item.opcode          = OP_WR_EDGE;
    item.entry_index     = idx;
    item.symbol          = sym;
    item.state_link_a    = target;
    item.link_edge       = next;
    item.link_edge_valid = next_ok;
    send_item(item);
  endtask

  task automatic scan_symbol(input logic [SYM_W-1:0] sym);
    in_item_t item;
    item        = random_item();
    item.opcode = OP_SCAN;
    item.symbol = sym;
    send_item(item);
  endtask

  task automatic return_to_root();
    in_item_t item;
    item        = random_item();
    item.opcode = OP_ROOT;
    send_item(item);
  endtask

  // random scans only: a walk that would be very long or touch unwritten entries
  // restarts from the root, and if the root itself is the problem it loses its children
  task automatic scan_guarded(input logic [SYM_W-1:0] sym);
    match_result_t res;
    int            cycles;
    bit            unsafe;
    predict_scan(sym, res, cycles, unsafe);
    if (unsafe || cycles > SCAN_CYCLE_CAP) begin
      return_to_root();
      predict_scan(sym, res, cycles, unsafe);
      if (unsafe || cycles > SCAN_CYCLE_CAP)
        write_node(ROOT, LINK_W'($urandom_range(0, EDGE_COUNT - 1)), 1'b0, ROOT, ROOT,
                   16'($urandom));
    end
    scan_symbol(sym);
  endtask

  // drop start, let every result come back and any write item settle
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic set_null_id(input logic [ID_W-1:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    null_id = value;
    cfg_wr_en <= 1'b0;
  endtask

  // childless root after reset: scan stays at root, null id still at its reset value 0
  task automatic test_reset_defaults();
    write_node(ROOT, LINK_W'($urandom_range(0, EDGE_COUNT - 1)), 1'b0, ROOT, ROOT, 16'h0000);
    scan_symbol(8'hA5);
  endtask

  // patterns lo-hi (id ffff) and hi (id 0001) on extreme bytes and table slots,
  // plus a hi child whose target is the root
  task automatic test_small_automaton();
    write_edge(EDGE_R_LO, SYM_LO, NODE_LO, EDGE_R_HI, 1'b1);
    write_edge(EDGE_R_HI, SYM_HI, NODE_HI, LINK_W'($urandom_range(0, EDGE_COUNT - 1)), 1'b0);
    write_edge(EDGE_LO_HI, SYM_HI, NODE_LOHI, LINK_W'($urandom_range(0, EDGE_COUNT - 1)),
               1'b0);
    write_edge(EDGE_BACK, SYM_BACK, ROOT, LINK_W'($urandom_range(0, EDGE_COUNT - 1)), 1'b0);
    write_node(NODE_LO, EDGE_LO_HI, 1'b1, ROOT, ROOT, 16'h8000);
    write_node(NODE_LOHI, LINK_W'($urandom_range(0, EDGE_COUNT - 1)), 1'b0, NODE_HI, NODE_LOHI,
               16'hFFFF);
    write_node(NODE_HI, EDGE_BACK, 1'b1, ROOT, NODE_HI, 16'h0001);
    write_node(ROOT, EDGE_R_LO, 1'b1, ROOT, ROOT, 16'h0000);
    scan_symbol(SYM_LO);    // first entry of the root list
    scan_symbol(SYM_HI);    // full pattern, longest match
    scan_symbol(SYM_HI);    // two failure hops before the root hit
    scan_symbol(SYM_BACK);  // hit that lands on the root
    scan_symbol(SYM_LO);
    return_to_root();       // mid-pattern restart
    scan_symbol(SYM_HI);    // hi from root, not lo-hi
    scan_symbol(SYM_STRAY); // miss all the way to the root
  endtask

  // null id at ffff, then 0001: a stored id equal to it is no match, root id 0 becomes one
  task automatic test_null_register();
    set_null_id(16'hFFFF);
    scan_symbol(SYM_LO);
    scan_symbol(SYM_HI);
    scan_symbol(SYM_STRAY);
    set_null_id(16'h0001);
    scan_symbol(SYM_HI);
  endtask

  // cyclic child list at the root, then a failure cycle that never reaches the root
  task automatic test_cyclic_links();
    write_edge(EDGE_R_HI, SYM_HI, NODE_HI, EDGE_R_LO, 1'b1);
    return_to_root();
    scan_symbol(SYM_STRAY); // full pass around the root list, miss
    scan_symbol(SYM_HI);
    write_node(NODE_HI, EDGE_BACK, 1'b1, NODE_LO, NODE_HI, 16'h0001);
    write_node(NODE_LO, EDGE_LO_HI, 1'b1, NODE_HI, ROOT, 16'h8000);
    scan_symbol(SYM_STRAY); // hi and lo fail to each other, forced back to root
  endtask

  // fresh random automaton; failure links mostly point at earlier nodes, a few anywhere
  task automatic build_random_automaton();
    int               n_nodes;
    int               n_edges;
    int               nxt;
    logic [LINK_W-1:0] idx;
    int               edge_parent[$];
    logic [SYM_W-1:0] edge_sym[$];
    logic [LINK_W-1:0] edge_target[$];
    trie_nodes.delete();
    trie_edges.delete();
    foreach (alphabet[k]) alphabet[k] = SYM_W'($urandom_range(0, 255));
    n_nodes = $urandom_range(3, 14);
    trie_nodes.push_back(ROOT);
    while (trie_nodes.size() < n_nodes) begin
      idx = LINK_W'($urandom_range(1, STATE_COUNT - 1));
      if (!in_list(trie_nodes, idx)) trie_nodes.push_back(idx);
    end
    n_edges = n_nodes - 1 + $urandom_range(0, 2);
    while (trie_edges.size() < n_edges) begin
      idx = LINK_W'($urandom_range(0, EDGE_COUNT - 1));
      if (!in_list(trie_edges, idx)) trie_edges.push_back(idx);
    end
    // edge k mostly leads into node k+1 from an earlier node; spare edges cross anywhere
    for (int k = 0; k < n_edges; k++) begin
      if (k < n_nodes - 1) begin
        edge_parent.push_back($urandom_range(0, k));
        edge_target.push_back(($urandom_range(0, 7) == 0) ? pick_node() : trie_nodes[k + 1]);
      end else begin
        edge_parent.push_back($urandom_range(0, n_nodes - 1));
        edge_target.push_back(pick_node());
      end
      edge_sym.push_back(alphabet[$urandom_range(0, 3)]);
    end
    // chain the children of each parent in edge order
    for (int k = 0; k < n_edges; k++) begin
      nxt = -1;
      for (int j = n_edges - 1; j > k; j--)
        if (edge_parent[j] == edge_parent[k]) nxt = j;
      if (nxt >= 0)
        write_edge(trie_edges[k], edge_sym[k], edge_target[k], trie_edges[nxt], 1'b1);
      else
        write_edge(trie_edges[k], edge_sym[k], edge_target[k],
                   LINK_W'($urandom_range(0, EDGE_COUNT - 1)), 1'b0);
    end
    for (int p = 0; p < n_nodes; p++) begin
      nxt = -1;
      for (int k = n_edges - 1; k >= 0; k--)
        if (edge_parent[k] == p) nxt = k;
      write_node(trie_nodes[p],
                 (nxt >= 0) ? trie_edges[nxt] : LINK_W'($urandom_range(0, EDGE_COUNT - 1)),
                 nxt >= 0,
                 (p == 0 || $urandom_range(0, 7) == 0) ? pick_node()
                                                       : trie_nodes[$urandom_range(0, p - 1)],
                 ($urandom_range(0, 1) == 0) ? trie_nodes[p] : pick_node(),
                 ($urandom_range(0, 3) == 0) ? null_id : ID_W'($urandom));
    end
  endtask

  // phases of: new null id, new automaton, a run of scans over its alphabet
  // with stray bytes, restarts and overwrites of live entries mixed in
  task automatic test_random_automata();
    int              pick;
    logic [ID_W-1:0] value;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 3))
        0:       value = '0;
        1:       value = '1;
        default: value = ID_W'($urandom);
      endcase
      set_null_id(value);
      build_random_automaton();
      repeat ($urandom_range(20, 60)) begin
        pick = $urandom_range(0, 31);
        if (pick == 0) begin
          return_to_root();
        end else if (pick == 1) begin
          write_node(pick_node(), pick_edge(), 1'($urandom_range(0, 1)), pick_node(),
                     pick_node(), ID_W'($urandom));
        end else if (pick == 2) begin
          write_edge(pick_edge(),
                     ($urandom_range(0, 1) == 0) ? alphabet[$urandom_range(0, 3)]
                                                 : SYM_W'($urandom),
                     pick_node(), pick_edge(), 1'($urandom_range(0, 1)));
        end else if (pick < 27) begin
          scan_guarded(alphabet[$urandom_range(0, 3)]);
        end else begin
          scan_guarded(SYM_W'($urandom));
        end
      end
    end
  endtask

  // results cannot be stalled: compare each strobe with the oldest expected item
  always @(posedge clk) begin : check_results
    match_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_matches.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual id %h found %b state %0d",
                 $time, out_match_id, out_match_found, out_new_state);
        error_count++;
      end else begin
        want = pending_matches.pop_front();
        if (out_match_id !== want.match_id) begin
          $display("%0t: match_id expected %h actual %h", $time, want.match_id, out_match_id);
          error_count++;
        end
        if (out_match_found !== want.match_found) begin
          $display("%0t: match_found expected %b actual %b", $time, want.match_found,
                   out_match_found);
          error_count++;
        end
        if (out_new_state !== want.new_state) begin
          $display("%0t: new_state expected %0d actual %0d", $time, want.new_state,
                   out_new_state);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_small_automaton();
    test_null_register();
    test_cyclic_links();
    test_random_automata();
    // drain: every expected item back, then a few quiet cycles for stray strobes
    wait_idle();
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #(TIMEOUT_TICKS);
    $display("Verification failed");
    $finish;
  end

endmodule
